// ----- rtl/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sample voice mixer package
// Shared constants, opcodes, controller states and the command bundle.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam int VOICES       = 8;
    localparam int SAMPLE_WORDS = 65536;

    localparam int ADDR_W   = $clog2(SAMPLE_WORDS);
    localparam int SLOT_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W    = $clog2(VOICES + 1);
    localparam int SAMPLE_W = 16;
    localparam int START_W  = 16;
    localparam int LEN_W    = 17;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_QUEUE   = 2'd1,
        OP_PRODUCE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_QUEUE,
        ST_WALK,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              latch;
        logic              write_en;
        logic              queue_en;
        logic              walk_en;
        logic [SLOT_W-1:0] slot;
        logic              load_out;
    } cmd_t;

endpackage

// ----- rtl/svm_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/svm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Sample voice mixer controller
// Sequences one beat at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
module svm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_op,
    output logic                m_valid,
    input  logic                m_ready,
    output svm_pkg::cmd_t       cmd
);

    svm_pkg::state_t                 state_reg, state_next;
    logic [svm_pkg::SLOT_W-1:0]      slot_cnt_reg, slot_cnt_next;
    logic                            m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= svm_pkg::ST_IDLE;
            slot_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_cnt_reg <= slot_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        slot_cnt_next = slot_cnt_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.slot      = slot_cnt_reg;
        unique case (state_reg)
            svm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch     = 1'b1;
                    slot_cnt_next = '0;
                    unique case (s_op)
                        svm_pkg::OP_WRITE:   state_next = svm_pkg::ST_WRITE;
                        svm_pkg::OP_QUEUE:   state_next = svm_pkg::ST_QUEUE;
                        svm_pkg::OP_PRODUCE: state_next = svm_pkg::ST_WALK;
                        default:             state_next = svm_pkg::ST_FINISH;
                    endcase
                end
            end
            svm_pkg::ST_WRITE: begin
                cmd.write_en = 1'b1;
                state_next   = svm_pkg::ST_FINISH;
            end
            svm_pkg::ST_QUEUE: begin
                cmd.queue_en = 1'b1;
                state_next   = svm_pkg::ST_FINISH;
            end
            svm_pkg::ST_WALK: begin
                cmd.walk_en = 1'b1;
                if (slot_cnt_reg == svm_pkg::SLOT_W'(svm_pkg::VOICES - 1)) begin
                    state_next = svm_pkg::ST_DRAIN;
                end else begin
                    slot_cnt_next = slot_cnt_reg + 1'b1;
                end
            end
            svm_pkg::ST_DRAIN: begin
                state_next = svm_pkg::ST_FINISH;
            end
            svm_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = svm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = svm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/svm_datapath.sv -----
// ----------------------------------------------------------------------------
// Sample voice mixer datapath
// Sample memory, voice slot table, saturating accumulator and result register.
// ----------------------------------------------------------------------------
module svm_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  svm_pkg::cmd_t                    cmd,
    input  logic [15:0]                      s_addr,
    input  logic signed [15:0]               s_sample_word,
    input  logic [16:0]                      s_sound_length,
    output logic signed [15:0]               m_mixed_sample,
    output logic                             m_queue_rejected,
    output logic [2:0]                       m_slot_used,
    output logic [3:0]                       m_voices_active
);

    localparam int ADDR_W   = svm_pkg::ADDR_W;
    localparam int SLOT_W   = svm_pkg::SLOT_W;
    localparam int CNT_W    = svm_pkg::CNT_W;
    localparam int SAMPLE_W = svm_pkg::SAMPLE_W;
    localparam int START_W  = svm_pkg::START_W;
    localparam int LEN_W    = svm_pkg::LEN_W;
    localparam int VOICES   = svm_pkg::VOICES;

    logic [VOICES-1:0]      active_reg;
    logic [START_W-1:0]     start_reg [VOICES];
    logic [LEN_W-1:0]       len_reg   [VOICES];
    logic [LEN_W-1:0]       pos_reg   [VOICES];

    logic [START_W-1:0]     addr_item_reg;
    logic [SAMPLE_W-1:0]    word_item_reg;
    logic [LEN_W-1:0]       len_item_reg;

    logic signed [SAMPLE_W-1:0] mix_reg;
    logic                       rej_reg;
    logic [2:0]                 slot_reg;
    logic                       rd_pend_reg;

    logic signed [SAMPLE_W-1:0] out_mix_reg;
    logic                       out_rej_reg;
    logic [2:0]                 out_slot_reg;
    logic [3:0]                 out_count_reg;

    logic [ADDR_W-1:0]          ram_addr;
    logic [SAMPLE_W-1:0]        ram_rdata;
    logic [LEN_W:0]             rd_sum;
    logic [LEN_W-1:0]           pos_inc;
    logic signed [SAMPLE_W:0]   acc_sum;
    logic signed [SAMPLE_W-1:0] acc_clamped;
    logic                       free_found;
    logic [SLOT_W-1:0]          free_idx;
    logic [CNT_W-1:0]           active_count;

    svm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (svm_pkg::SAMPLE_WORDS)
    ) u_sample_ram (
        .aclk  (aclk),
        .we    (cmd.write_en),
        .addr  (ram_addr),
        .wdata (word_item_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        rd_sum  = (LEN_W + 1)'(start_reg[cmd.slot]) + (LEN_W + 1)'(pos_reg[cmd.slot]);
        pos_inc = pos_reg[cmd.slot] + 1'b1;
        if (cmd.walk_en) begin
            ram_addr = ADDR_W'(rd_sum);
        end else begin
            ram_addr = ADDR_W'(addr_item_reg);
        end
    end

    always_comb begin
        acc_sum = (SAMPLE_W + 1)'(mix_reg) + (SAMPLE_W + 1)'(signed'(ram_rdata));
        if (acc_sum > (SAMPLE_W + 1)'(signed'(17'sd32767))) begin
            acc_clamped = 16'sh7fff;
        end else if (acc_sum < (SAMPLE_W + 1)'(signed'(-17'sd32768))) begin
            acc_clamped = 16'sh8000;
        end else begin
            acc_clamped = SAMPLE_W'(acc_sum);
        end
    end

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!active_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        active_count = '0;
        for (int i = 0; i < VOICES; i++) begin
            active_count = active_count + CNT_W'(active_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.walk_en && active_reg[cmd.slot];
            if (cmd.queue_en && len_item_reg != '0 && free_found) begin
                active_reg[free_idx] <= 1'b1;
            end else if (cmd.walk_en && active_reg[cmd.slot] &&
                         pos_inc >= len_reg[cmd.slot]) begin
                active_reg[cmd.slot] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            addr_item_reg <= s_addr;
            word_item_reg <= s_sample_word;
            len_item_reg  <= s_sound_length;
            mix_reg       <= '0;
            rej_reg       <= 1'b0;
            slot_reg      <= '0;
        end
        if (rd_pend_reg) begin
            mix_reg <= acc_clamped;
        end
        if (cmd.queue_en) begin
            if (len_item_reg == '0 || !free_found) begin
                rej_reg <= 1'b1;
            end else begin
                start_reg[free_idx] <= addr_item_reg;
                len_reg[free_idx]   <= len_item_reg;
                pos_reg[free_idx]   <= '0;
                slot_reg            <= 3'(free_idx);
            end
        end
        if (cmd.walk_en && active_reg[cmd.slot]) begin
            pos_reg[cmd.slot] <= pos_inc;
        end
        if (cmd.load_out) begin
            out_mix_reg   <= mix_reg;
            out_rej_reg   <= rej_reg;
            out_slot_reg  <= slot_reg;
            out_count_reg <= 4'(active_count);
        end
    end

    assign m_mixed_sample   = out_mix_reg;
    assign m_queue_rejected = out_rej_reg;
    assign m_slot_used      = out_slot_reg;
    assign m_voices_active  = out_count_reg;

endmodule

// ----- rtl/sample_voice_mixer.sv -----
// ----------------------------------------------------------------------------
// Sample voice mixer
// Multi-voice PCM sample player with a saturating mix, one result per beat.
//
// The s_ channel takes one beat per command: write a sample word, queue a
// sound in the lowest free voice slot, or produce one mixed output sample.
// Every input beat yields exactly one m_ beat, in order.
// Commands are handled one at a time. A write or queue beat passes through
// the WRITE or QUEUE state and then FINISH, where its result is loaded into
// the output register; the next beat is accepted once the controller is back
// in IDLE. A produce beat walks every voice slot, one slot per cycle through
// the single sample memory port, then passes DRAIN and FINISH before its
// result is offered.
// The result sits in an output register, so the next beat is accepted while
// the previous result is still waiting; if the receiver stalls, the block
// holds the finished result internally until the output register frees.
// Reset clears all voice slots and the result valid flag; the sample memory
// is not cleared and must be written before sounds refer to it.
// ----------------------------------------------------------------------------
module sample_voice_mixer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_op,
    input  logic [15:0]        s_addr,
    input  logic signed [15:0] s_sample_word,
    input  logic [16:0]        s_sound_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_mixed_sample,
    output logic               m_queue_rejected,
    output logic [2:0]         m_slot_used,
    output logic [3:0]         m_voices_active
);

    svm_pkg::cmd_t cmd;

    svm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    svm_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .s_addr           (s_addr),
        .s_sample_word    (s_sample_word),
        .s_sound_length   (s_sound_length),
        .m_mixed_sample   (m_mixed_sample),
        .m_queue_rejected (m_queue_rejected),
        .m_slot_used      (m_slot_used),
        .m_voices_active  (m_voices_active)
    );

endmodule

// ----- rtl/svm_checker.sv -----
// ----------------------------------------------------------------------------
// Sample voice mixer checker
// Port-level properties of the mixer, bound to the top level.
// ----------------------------------------------------------------------------
module svm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_mixed_sample,
    input logic               m_queue_rejected,
    input logic [2:0]         m_slot_used,
    input logic [3:0]         m_voices_active
);

    a_reset_clears_valid: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid not cleared by reset");

    a_stalled_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mixed_sample) &&
            $stable(m_queue_rejected) && $stable(m_slot_used) && $stable(m_voices_active))
        else $error("stalled result beat changed");

    a_one_beat_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in progress");

    a_reject_fields_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_queue_rejected |-> m_slot_used == 3'd0 && m_mixed_sample == 16'sd0)
        else $error("rejected queue result carries slot or sample");

    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 32'(m_voices_active) <= svm_pkg::VOICES)
        else $error("active voice count exceeds slot count");

endmodule

bind sample_voice_mixer svm_checker u_svm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_mixed_sample   (m_mixed_sample),
    .m_queue_rejected (m_queue_rejected),
    .m_slot_used      (m_slot_used),
    .m_voices_active  (m_voices_active)
);
